/* rtl/core/smdi_pkg.sv */
`default_nettype none
package smdi_pkg;

	localparam int DATA_W  = 32;
	localparam int IDX_W   = 4;
	localparam int ST_W    = 2;
	localparam int ACC_W   = 38;
	localparam int NPERM   = 24;
	localparam int PERM_W  = 5;
	localparam int PCOL_W  = 2;
	localparam int PROWS   = 4;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_SING = 2'd1;
	localparam logic [ST_W-1:0] ST_SAT  = 2'd2;

	localparam logic REG_SIZE = 1'b0;
	localparam logic REG_MODE = 1'b1;

	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	// permutations of four columns in lexicographic order, packed {p3,p2,p1,p0}
	localparam logic [7:0] PERM_COLS [NPERM] = '{
		8'hE4, 8'hB4, 8'hD8, 8'h78, 8'h9C, 8'h6C,
		8'hE1, 8'hB1, 8'hC9, 8'h39, 8'h8D, 8'h2D,
		8'hD2, 8'h72, 8'hC6, 8'h36, 8'h4E, 8'h1E,
		8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B
	};

	// bit i set: permutation i is odd
	localparam logic [NPERM-1:0] PERM_ODD = 24'h666666;

endpackage
`default_nettype wire

/* rtl/core/smdi_store.sv */
`default_nettype none
module smdi_store #(
	parameter int MAX_DIM = 4
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    waddr,
	input  wire logic signed [smdi_pkg::DATA_W-1:0]    wdata,
	input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    raddr,
	output logic signed [smdi_pkg::DATA_W-1:0]         rdata
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic signed [smdi_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/smdi_qmul.sv */
`default_nettype none
module smdi_qmul #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic signed [smdi_pkg::DATA_W-1:0] a,
	input  wire logic signed [smdi_pkg::DATA_W-1:0] b,
	output logic signed [smdi_pkg::DATA_W-1:0]      res,
	output logic                                    sat
);

	localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);

	logic signed [63:0] prod_s1;
	logic signed [64:0] rnd;
	logic signed [64:0] shf;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_comb begin
		rnd = {prod_s1[63], prod_s1} + HALF;
		shf = rnd >>> FRAC_BITS;
		sat = !((&shf[64:31]) || !(|shf[64:31]));
		if (sat) begin
			res = shf[64] ? smdi_pkg::Q_MIN : smdi_pkg::Q_MAX;
		end else begin
			res = shf[31:0];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/smdi_qdiv.sv */
`default_nettype none
module smdi_qdiv #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [smdi_pkg::DATA_W:0]   num,
	input  wire logic signed [smdi_pkg::DATA_W-1:0] den,
	output logic                                    done,
	output logic signed [smdi_pkg::DATA_W-1:0]      res,
	output logic                                    sat
);

	localparam int DW  = smdi_pkg::DATA_W + FRAC_BITS;
	localparam int CNW = $clog2(DW + 1);

	logic [DW-1:0]  quo_q;
	logic [31:0]    rem_q;
	logic [31:0]    md_q;
	logic           neg_q;
	logic           run_q;
	logic [CNW-1:0] cnt_q;

	logic [31:0]    mn;
	logic [31:0]    md;
	logic [32:0]    rem_sh;
	logic           fit;
	logic           big;

	always_comb begin
		mn = num[smdi_pkg::DATA_W] ? 32'(-num) : num[31:0];
		md = den[smdi_pkg::DATA_W-1] ? 32'(-{den[31], den}) : den[31:0];
		rem_sh = {rem_q, quo_q[DW-1]};
		fit = rem_sh >= {1'b0, md_q};
		big = (|quo_q[DW-1:32]) || (quo_q[31] && (|quo_q[30:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
			quo_q <= '0;
			rem_q <= '0;
			md_q  <= '0;
			neg_q <= 1'b0;
			res   <= '0;
			sat   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				quo_q <= (DW'(mn) << FRAC_BITS) + DW'(md >> 1);
				md_q  <= md;
				neg_q <= num[smdi_pkg::DATA_W] != den[smdi_pkg::DATA_W-1];
				rem_q <= '0;
				cnt_q <= CNW'(DW);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (cnt_q != '0) begin
					rem_q <= fit ? 32'(rem_sh - {1'b0, md_q}) : rem_sh[31:0];
					quo_q <= {quo_q[DW-2:0], fit};
					cnt_q <= cnt_q - 1'b1;
				end else begin
					run_q <= 1'b0;
					done  <= 1'b1;
					if (big) begin
						sat <= 1'b1;
						res <= neg_q ? smdi_pkg::Q_MIN : smdi_pkg::Q_MAX;
					end else if (neg_q) begin
						sat <= 1'b0;
						res <= -quo_q[31:0];
					end else if (quo_q[31]) begin
						sat <= 1'b1;
						res <= smdi_pkg::Q_MAX;
					end else begin
						sat <= 1'b0;
						res <= quo_q[31:0];
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/smdi_seq.sv */
`default_nettype none
module smdi_seq #(
	parameter int MAX_DIM   = 4,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [$clog2(MAX_DIM+1)-1:0]          start_n,
	input  wire logic                                  start_mode,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]         raddr,
	input  wire logic signed [smdi_pkg::DATA_W-1:0]    rdata,
	output logic                                       busy,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [smdi_pkg::DATA_W-1:0]         out_value,
	output logic [smdi_pkg::IDX_W-1:0]                 out_index,
	output logic signed [smdi_pkg::DATA_W-1:0]         out_det,
	output logic [smdi_pkg::ST_W-1:0]                  out_status,
	output logic                                       out_last
);

	localparam int NW  = $clog2(MAX_DIM + 1);
	localparam int RW  = $clog2(MAX_DIM);
	localparam int AW  = $clog2(MAX_DIM * MAX_DIM);
	localparam int XW  = 2 * NW + 2;
	localparam int AC  = smdi_pkg::ACC_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_PERM = 4'd2;
	localparam logic [3:0] S_RD   = 4'd3;
	localparam logic [3:0] S_DAT  = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_STEP = 4'd6;
	localparam logic [3:0] S_FIN  = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_DIVW = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;
	localparam logic [3:0] S_ADV  = 4'd11;
	localparam logic [3:0] S_ZERO = 4'd12;

	logic [3:0]                          state_q;
	logic [NW-1:0]                       n_q;
	logic                                mode_q;
	logic                                minor_q;
	logic [RW-1:0]                       r_q;
	logic [RW-1:0]                       c_q;
	logic [smdi_pkg::PERM_W-1:0]         perm_q;
	logic [smdi_pkg::PCOL_W-1:0]         row_q;
	logic signed [smdi_pkg::DATA_W-1:0]  partial_q;
	logic                                lsat_q;
	logic signed [AC-1:0]                acc_q;
	logic signed [smdi_pkg::DATA_W-1:0]  det_q;
	logic                                dsat_q;
	logic                                msat_q;
	logic signed [smdi_pkg::DATA_W:0]    cof_q;

	logic [NW-1:0]                       k;
	logic [7:0]                          cols;
	logic                                odd;
	logic                                perm_ok;
	logic [smdi_pkg::PCOL_W-1:0]         col_sel;
	logic [smdi_pkg::PCOL_W:0]           orow;
	logic [smdi_pkg::PCOL_W:0]           ocol;
	logic [XW-1:0]                       addr_w;
	logic                                row_last;
	logic                                perm_end;
	logic signed [AC-1:0]                term;
	logic                                fin_sat;
	logic signed [smdi_pkg::DATA_W-1:0]  fin_val;
	logic [smdi_pkg::IDX_W-1:0]          idx;
	logic [2*NW-1:0]                     nn;
	logic                                last;
	logic [smdi_pkg::ST_W-1:0]           det_st;

	logic signed [smdi_pkg::DATA_W-1:0]  mul_res;
	logic                                mul_sat;
	logic                                div_done;
	logic signed [smdi_pkg::DATA_W-1:0]  div_res;
	logic                                div_sat;

	smdi_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
		.clk (clk),
		.a   (partial_q),
		.b   (rdata),
		.res (mul_res),
		.sat (mul_sat)
	);

	smdi_qdiv #(.FRAC_BITS(FRAC_BITS)) u_qdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_DIV),
		.num    (cof_q),
		.den    (det_q),
		.done   (div_done),
		.res    (div_res),
		.sat    (div_sat)
	);

	always_comb begin
		k = n_q - NW'(minor_q);
		cols = smdi_pkg::PERM_COLS[perm_q];
		odd = smdi_pkg::PERM_ODD[perm_q];
		perm_ok = 1'b1;
		for (int i = 0; i < smdi_pkg::PROWS; i++) begin
			if (NW'(i) >= k) begin
				if (cols[2*i +: 2] != 2'(i)) perm_ok = 1'b0;
			end else begin
				if (NW'(cols[2*i +: 2]) >= k) perm_ok = 1'b0;
			end
		end
		col_sel = cols[2*row_q +: 2];
		orow = {1'b0, row_q}
			+ 3'(minor_q && (row_q >= smdi_pkg::PCOL_W'(c_q)));
		ocol = {1'b0, col_sel}
			+ 3'(minor_q && (col_sel >= smdi_pkg::PCOL_W'(r_q)));
		addr_w = XW'(orow) + XW'(ocol) * XW'(n_q);
		raddr = addr_w[AW-1:0];
		row_last = NW'(row_q) == (k - 1'b1);
		perm_end = perm_q == smdi_pkg::PERM_W'(smdi_pkg::NPERM - 1);
		term = odd ? -AC'(partial_q) : AC'(partial_q);
		fin_sat = !((&acc_q[AC-1:31]) || !(|acc_q[AC-1:31]));
		if (fin_sat) begin
			fin_val = acc_q[AC-1] ? smdi_pkg::Q_MIN : smdi_pkg::Q_MAX;
		end else begin
			fin_val = acc_q[31:0];
		end
		nn = n_q * n_q;
		idx = smdi_pkg::IDX_W'(r_q) + smdi_pkg::IDX_W'(c_q) * smdi_pkg::IDX_W'(n_q);
		last = idx == smdi_pkg::IDX_W'(nn - 1'b1);
		if (fin_val == '0) begin
			det_st = smdi_pkg::ST_SING;
		end else if (lsat_q || fin_sat) begin
			det_st = smdi_pkg::ST_SAT;
		end else begin
			det_st = smdi_pkg::ST_OK;
		end
		busy = state_q != S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			n_q        <= '0;
			mode_q     <= 1'b0;
			minor_q    <= 1'b0;
			r_q        <= '0;
			c_q        <= '0;
			perm_q     <= '0;
			row_q      <= '0;
			partial_q  <= '0;
			lsat_q     <= 1'b0;
			acc_q      <= '0;
			det_q      <= '0;
			dsat_q     <= 1'b0;
			msat_q     <= 1'b0;
			cof_q      <= '0;
			out_valid  <= 1'b0;
			out_value  <= '0;
			out_index  <= '0;
			out_det    <= '0;
			out_status <= smdi_pkg::ST_OK;
			out_last   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						n_q     <= start_n;
						mode_q  <= start_mode;
						minor_q <= 1'b0;
						r_q     <= '0;
						c_q     <= '0;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					perm_q <= '0;
					lsat_q <= 1'b0;
					if (k == '0) begin
						acc_q   <= AC'(1) <<< FRAC_BITS;
						state_q <= S_FIN;
					end else begin
						acc_q   <= '0;
						state_q <= S_PERM;
					end
				end
				S_PERM: begin
					if (perm_ok) begin
						row_q   <= '0;
						state_q <= S_RD;
					end else if (perm_end) begin
						state_q <= S_FIN;
					end else begin
						perm_q <= perm_q + 1'b1;
					end
				end
				S_RD: begin
					state_q <= S_DAT;
				end
				S_DAT: begin
					if (row_q == '0) begin
						partial_q <= rdata;
						state_q   <= S_STEP;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					partial_q <= mul_res;
					lsat_q    <= lsat_q | mul_sat;
					state_q   <= S_STEP;
				end
				S_STEP: begin
					if (row_last) begin
						acc_q <= acc_q + term;
						if (perm_end) begin
							state_q <= S_FIN;
						end else begin
							perm_q  <= perm_q + 1'b1;
							state_q <= S_PERM;
						end
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					if (!minor_q) begin
						det_q  <= fin_val;
						dsat_q <= lsat_q | fin_sat;
						if (!mode_q) begin
							out_value  <= fin_val;
							out_index  <= '0;
							out_det    <= fin_val;
							out_status <= det_st;
							out_last   <= 1'b1;
							out_valid  <= 1'b1;
							state_q    <= S_OUT;
						end else if (fin_val == '0) begin
							state_q <= S_ZERO;
						end else begin
							minor_q <= 1'b1;
							state_q <= S_INIT;
						end
					end else begin
						cof_q   <= (r_q[0] ^ c_q[0]) ? -33'(fin_val) : 33'(fin_val);
						msat_q  <= dsat_q | lsat_q | fin_sat;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						out_value  <= div_res;
						out_index  <= idx;
						out_det    <= det_q;
						out_status <= (msat_q | div_sat) ? smdi_pkg::ST_SAT : smdi_pkg::ST_OK;
						out_last   <= last;
						out_valid  <= 1'b1;
						state_q    <= S_OUT;
					end
				end
				S_ZERO: begin
					out_value  <= '0;
					out_index  <= idx;
					out_det    <= det_q;
					out_status <= smdi_pkg::ST_SING;
					out_last   <= last;
					out_valid  <= 1'b1;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= S_ADV;
					end
				end
				S_ADV: begin
					if (out_last) begin
						state_q <= S_IDLE;
					end else begin
						if (r_q == RW'(n_q - 1'b1)) begin
							r_q <= '0;
							c_q <= c_q + 1'b1;
						end else begin
							r_q <= r_q + 1'b1;
						end
						state_q <= (det_q == '0) ? S_ZERO : S_INIT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/small_matrix_det_inverse.sv */
// Determinant and inverse of a square matrix, signed fixed point Q(31-F).F.
// Configure matrix_size (address 0) and op_mode (address 4) over the APB port
// while the block is idle. Elements enter on in_valid/in_stall in column-major
// order, one transaction per element, one per cycle while loading.
// When size*size elements are in, in_stall rises and the block computes the
// determinant by Leibniz expansion on one shared multiplier: each expansion
// covers one k x k matrix, the full matrix or a minor of it.
// Determinant mode emits one transaction. Inverse mode emits size*size
// transactions, column-major, each a cofactor expansion followed by a
// restoring division, the final one with out_last set.
// A singular matrix gives zero values with status 1, without the divisions.
// Each result sits in the output register until taken; a stalled receiver
// just holds the sequencer. in_stall falls after the last result transaction
// is taken. Reset clears the load count, sets size 4 and inverse mode.
`default_nettype none
module small_matrix_det_inverse #(
	parameter int MAX_DIM   = 4,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [2:0]                         paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [smdi_pkg::DATA_W-1:0] elem_value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [smdi_pkg::DATA_W-1:0]      out_value,
	output logic [smdi_pkg::IDX_W-1:0]              out_index,
	output logic signed [smdi_pkg::DATA_W-1:0]      out_det,
	output logic [smdi_pkg::ST_W-1:0]               out_status,
	output logic                                    out_last
);

	localparam int NW = $clog2(MAX_DIM + 1);
	localparam int AW = $clog2(MAX_DIM * MAX_DIM);
	localparam int CW = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int PW = 2 * NW + 1;

	logic [2:0]    size_q;
	logic          mode_q;
	logic [CW-1:0] cnt_q;

	logic          wr;
	logic          accept;
	logic          complete;
	logic [NW-1:0] n_in;
	logic [PW-1:0] nn;
	logic          busy;

	logic [AW-1:0]                      raddr;
	logic signed [smdi_pkg::DATA_W-1:0] rdata;

	always_comb begin
		pready = 1'b1;
		wr = psel && penable && pwrite;
		unique case (paddr[2])
			smdi_pkg::REG_SIZE: prdata = {29'd0, size_q};
			smdi_pkg::REG_MODE: prdata = {31'd0, mode_q};
		endcase
		if (size_q == 3'd0) begin
			n_in = NW'(1);
		end else if (size_q > 3'(MAX_DIM)) begin
			n_in = NW'(MAX_DIM);
		end else begin
			n_in = size_q[NW-1:0];
		end
		nn = PW'(n_in) * PW'(n_in);
		in_stall = busy;
		accept = in_valid && !in_stall;
		complete = accept && ((PW'(cnt_q) + 1'b1) >= nn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 3'd4;
			mode_q <= 1'b1;
		end else if (wr) begin
			unique case (paddr[2])
				smdi_pkg::REG_SIZE: size_q <= pwdata[2:0];
				smdi_pkg::REG_MODE: mode_q <= pwdata[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= complete ? '0 : cnt_q + 1'b1;
		end
	end

	smdi_store #(.MAX_DIM(MAX_DIM)) u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (cnt_q[AW-1:0]),
		.wdata (elem_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	smdi_seq #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (complete),
		.start_n    (n_in),
		.start_mode (mode_q),
		.raddr      (raddr),
		.rdata      (rdata),
		.busy       (busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_value  (out_value),
		.out_index  (out_index),
		.out_det    (out_det),
		.out_status (out_status),
		.out_last   (out_last)
	);

endmodule
`default_nettype wire
